/* hw/rtl/scaled_tinted_sprite_sampler_macros.svh */
// Assertion macros for the scaled tinted sprite sampler checker.
// Depends on nothing; included by the checker file.
`ifndef SCALED_TINTED_SPRITE_SAMPLER_MACROS_SVH
`define SCALED_TINTED_SPRITE_SAMPLER_MACROS_SVH

// The consequent must hold at the clock after the antecedent.
`define STS_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold after the delay given by the n argument.
`define STS_ASSERT_DELAY(label, clk_i, rstn_i, ante, n, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

/* hw/rtl/sts_pkg.sv */
// Shared types and constants of the scaled tinted sprite sampler.
// Depends on nothing; used by the top level and its checker.
package sts_pkg;

	localparam int ADDR_W      = 12;
	localparam int STORE_DEPTH = 4096;
	localparam int RGBA_W      = 32;
	localparam int COL_W       = 10;
	localparam int ROW_W       = 10;
	localparam int CHAN_W      = 8;
	localparam int PADDR_W     = 5;
	localparam int APB_DW      = 32;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		REG_TEX_WIDTH   = 3'd0,
		REG_TEX_HEIGHT  = 3'd1,
		REG_TILE_GRID   = 3'd2,
		REG_TILE_INDEX  = 3'd3,
		REG_DEST_WIDTH  = 3'd4,
		REG_DEST_HEIGHT = 3'd5,
		REG_TINT        = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] texel_addr;
		logic [RGBA_W-1:0] texel_rgba;
		logic [COL_W-1:0]  dest_col;
		logic [ROW_W-1:0]  dest_row;
	} cmd_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
		logic [COL_W-1:0]  out_col;
		logic [ROW_W-1:0]  out_row;
	} res_t;

endpackage

/* hw/rtl/sts_ram.sv */
// Generic single-port synchronous RAM with a registered, read-first output.
// Depends on nothing.
module sts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* hw/rtl/scaled_tinted_sprite_sampler.sv */
// Scaled tinted sprite sampler: nearest-neighbor tile lookup in a texel RAM with RGB tint.
// Depends on sts_pkg and sts_ram. One item is taken per cycle when busy is low.
// A sample item shows its result with done high after stages s1 and s2, the one-bit-per-stage
// divider stages s3, stages s4 to s7 and the done register.
// Reset loads the register defaults; after reset and after every register write, busy stays
// high through the load, divide and offset states while tile sizes and tile offsets are recomputed.
module scaled_tinted_sprite_sampler
	import sts_pkg::*;
#(
	parameter int TEX_WIDTH_MAX  = 64,
	parameter int TEX_HEIGHT_MAX = 64,
	parameter int DEST_DIM_MAX   = 1024,
	parameter int GRID_MAX       = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cmd_t               cmd,
	output logic               done,
	output res_t               result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	localparam int TEXW_W = 7;
	localparam int GRID_W = 5;
	localparam int IDX_W  = 8;
	localparam int DIM_W  = 11;
	localparam int TINT_W = 32;

	localparam logic [CHAN_W-1:0] FULL = 8'hFF;

	localparam int TWW  = $clog2(TEX_WIDTH_MAX + 1);
	localparam int THW  = $clog2(TEX_HEIGHT_MAX + 1);
	localparam int GW   = $clog2(GRID_MAX + 1);
	localparam int DW   = $clog2(DEST_DIM_MAX + 1);
	localparam int NDIV = (TWW > THW) ? ((TWW > IDX_W) ? TWW : IDX_W)
	                                  : ((THW > IDX_W) ? THW : IDX_W);
	localparam int CNTW = $clog2(NDIV + 1);
	localparam int PXW  = COL_W + TWW;
	localparam int PYW  = ROW_W + THW;
	localparam int NS   = (PXW > PYW) ? PXW : PYW;
	localparam int OXW  = TWW + GW;
	localparam int OYW  = THW + IDX_W;
	localparam int CW0  = (NS > OXW) ? NS : OXW;
	localparam int CW   = ((CW0 > OYW) ? CW0 : OYW) + 1;
	localparam int PAW  = (THW + TWW + 1 > ADDR_W) ? THW + TWW + 1 : ADDR_W;

	typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_OFF} seq_state_t;

	logic [TEXW_W-1:0] cfg_tex_w_q, cfg_tex_h_q;
	logic [GRID_W-1:0] cfg_grid_q;
	logic [IDX_W-1:0]  cfg_idx_q;
	logic [DIM_W-1:0]  cfg_dest_w_q, cfg_dest_h_q;
	logic [TINT_W-1:0] cfg_tint_q;

	logic       cfg_wr;
	logic [2:0] cfg_sel;
	logic       accept;

	logic [TWW-1:0] tw_sat;
	logic [THW-1:0] th_sat;
	logic [GW-1:0]  grid_sat;
	logic [DW-1:0]  dw_sat, dh_sat;

	seq_state_t      state_q;
	logic [CNTW-1:0] cnt_q;
	logic [NDIV-1:0] dvd_q [3];
	logic [GW-1:0]   rem_q [3];
	logic [NDIV-1:0] dvd_nxt [3];
	logic [GW-1:0]   rem_nxt [3];
	logic [TWW-1:0]  tw_q, tile_w_q;
	logic [THW-1:0]  th_q, tile_h_q;
	logic [DW-1:0]   dw_q, dh_q;
	logic [OXW-1:0]  offx_q;
	logic [OYW-1:0]  offy_q;

	logic          vld_s1, vld_s2;
	cmd_t          cmd_s1, cmd_s2;
	logic [NS-1:0] px_s2, py_s2;

	logic          vld_s3 [NS];
	cmd_t          cmd_s3 [NS];
	logic [NS-1:0] dvx_s3 [NS];
	logic [NS-1:0] dvy_s3 [NS];
	logic [DW-1:0] rmx_s3 [NS];
	logic [DW-1:0] rmy_s3 [NS];
	logic [NS-1:0] dvx_nxt [NS];
	logic [NS-1:0] dvy_nxt [NS];
	logic [DW-1:0] rmx_nxt [NS];
	logic [DW-1:0] rmy_nxt [NS];

	logic [CW-1:0]  cx, cy;
	logic           vld_s4;
	cmd_t           cmd_s4;
	logic [TWW-1:0] tx_s4;
	logic [THW-1:0] ty_s4;

	logic [PAW-1:0]    pix_addr;
	logic              vld_s5, op_s5;
	logic [ADDR_W-1:0] ram_addr_s5;
	logic [RGBA_W-1:0] rgba_s5;
	logic [COL_W-1:0]  col_s5, col_s6, col_s7;
	logic [ROW_W-1:0]  row_s5, row_s6, row_s7;

	logic              vld_s6;
	logic [RGBA_W-1:0] texel;

	logic                vld_s7;
	logic [2*CHAN_W-1:0] prod_r_s7, prod_g_s7, prod_b_s7;
	logic [CHAN_W-1:0]   alpha_s7;

	logic done_q;
	res_t result_q;

	function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
		logic [2*CHAN_W:0] s;
		s = (2*CHAN_W+1)'(p) + (2*CHAN_W+1)'(p[2*CHAN_W-1:CHAN_W]) + (2*CHAN_W+1)'(1);
		return s[2*CHAN_W-1:CHAN_W];
	endfunction

	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_sel = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign busy    = (state_q != ST_IDLE) || cfg_wr;
	assign accept  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_tex_w_q  <= TEXW_W'(64);
			cfg_tex_h_q  <= TEXW_W'(64);
			cfg_grid_q   <= GRID_W'(1);
			cfg_idx_q    <= '0;
			cfg_dest_w_q <= DIM_W'(64);
			cfg_dest_h_q <= DIM_W'(64);
			cfg_tint_q   <= '1;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_TEX_WIDTH:   cfg_tex_w_q  <= pwdata[TEXW_W-1:0];
				REG_TEX_HEIGHT:  cfg_tex_h_q  <= pwdata[TEXW_W-1:0];
				REG_TILE_GRID:   cfg_grid_q   <= pwdata[GRID_W-1:0];
				REG_TILE_INDEX:  cfg_idx_q    <= pwdata[IDX_W-1:0];
				REG_DEST_WIDTH:  cfg_dest_w_q <= pwdata[DIM_W-1:0];
				REG_DEST_HEIGHT: cfg_dest_h_q <= pwdata[DIM_W-1:0];
				REG_TINT:        cfg_tint_q   <= pwdata[TINT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_TEX_WIDTH:   prdata = APB_DW'(cfg_tex_w_q);
			REG_TEX_HEIGHT:  prdata = APB_DW'(cfg_tex_h_q);
			REG_TILE_GRID:   prdata = APB_DW'(cfg_grid_q);
			REG_TILE_INDEX:  prdata = APB_DW'(cfg_idx_q);
			REG_DEST_WIDTH:  prdata = APB_DW'(cfg_dest_w_q);
			REG_DEST_HEIGHT: prdata = APB_DW'(cfg_dest_h_q);
			REG_TINT:        prdata = APB_DW'(cfg_tint_q);
			default:         prdata = '0;
		endcase
	end

	// Zero acts as one and values above the maximum saturate.
	always_comb begin
		tw_sat = (cfg_tex_w_q == '0) ? TWW'(1) :
			((32'(cfg_tex_w_q) > 32'(TEX_WIDTH_MAX)) ? TWW'(TEX_WIDTH_MAX) : TWW'(cfg_tex_w_q));
		th_sat = (cfg_tex_h_q == '0) ? THW'(1) :
			((32'(cfg_tex_h_q) > 32'(TEX_HEIGHT_MAX)) ? THW'(TEX_HEIGHT_MAX) : THW'(cfg_tex_h_q));
		grid_sat = (cfg_grid_q == '0) ? GW'(1) :
			((32'(cfg_grid_q) > 32'(GRID_MAX)) ? GW'(GRID_MAX) : GW'(cfg_grid_q));
		dw_sat = (cfg_dest_w_q == '0) ? DW'(1) :
			((32'(cfg_dest_w_q) > 32'(DEST_DIM_MAX)) ? DW'(DEST_DIM_MAX) : DW'(cfg_dest_w_q));
		dh_sat = (cfg_dest_h_q == '0) ? DW'(1) :
			((32'(cfg_dest_h_q) > 32'(DEST_DIM_MAX)) ? DW'(DEST_DIM_MAX) : DW'(cfg_dest_h_q));
	end

	// Restoring division by the grid size, one quotient bit per cycle, for the tile width,
	// the tile height and the tile row and column.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if ({rem_q[k], dvd_q[k][NDIV-1]} >= {1'b0, grid_sat}) begin
				rem_nxt[k] = GW'({rem_q[k], dvd_q[k][NDIV-1]} - {1'b0, grid_sat});
				dvd_nxt[k] = {dvd_q[k][NDIV-2:0], 1'b1};
			end else begin
				rem_nxt[k] = GW'({rem_q[k], dvd_q[k][NDIV-1]});
				dvd_nxt[k] = {dvd_q[k][NDIV-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			cnt_q    <= '0;
			dvd_q    <= '{default: '0};
			rem_q    <= '{default: '0};
			tw_q     <= '0;
			th_q     <= '0;
			dw_q     <= '0;
			dh_q     <= '0;
			tile_w_q <= '0;
			tile_h_q <= '0;
			offx_q   <= '0;
			offy_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_LOAD: begin
					dvd_q[0] <= NDIV'(tw_sat);
					dvd_q[1] <= NDIV'(th_sat);
					dvd_q[2] <= NDIV'(cfg_idx_q);
					rem_q    <= '{default: '0};
					cnt_q    <= CNTW'(NDIV);
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					dvd_q <= dvd_nxt;
					rem_q <= rem_nxt;
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1)) begin
						state_q <= ST_OFF;
					end
				end
				ST_OFF: begin
					tw_q     <= tw_sat;
					th_q     <= th_sat;
					dw_q     <= dw_sat;
					dh_q     <= dh_sat;
					tile_w_q <= dvd_q[0][TWW-1:0];
					tile_h_q <= dvd_q[1][THW-1:0];
					offx_q   <= OXW'(dvd_q[0][TWW-1:0]) * OXW'(rem_q[2]);
					offy_q   <= OYW'(dvd_q[1][THW-1:0]) * OYW'(dvd_q[2][IDX_W-1:0]);
					state_q  <= ST_IDLE;
				end
			endcase
			if (cfg_wr) begin
				state_q <= ST_LOAD;
			end
		end
	end

	// Divider pipeline: stage j of each axis resolves one quotient bit of pos * tile / dest.
	for (genvar j = 0; j < NS; j++) begin : g_div
		logic [NS-1:0] dx_in, dy_in;
		logic [DW-1:0] rx_in, ry_in;
		logic [DW:0]   sx, sy;
		logic          gex, gey;
		if (j == 0) begin : g_first
			assign dx_in = px_s2;
			assign dy_in = py_s2;
			assign rx_in = '0;
			assign ry_in = '0;
		end else begin : g_next
			assign dx_in = dvx_s3[j-1];
			assign dy_in = dvy_s3[j-1];
			assign rx_in = rmx_s3[j-1];
			assign ry_in = rmy_s3[j-1];
		end
		assign sx         = {rx_in, dx_in[NS-1]};
		assign sy         = {ry_in, dy_in[NS-1]};
		assign gex        = sx >= {1'b0, dw_q};
		assign gey        = sy >= {1'b0, dh_q};
		assign dvx_nxt[j] = {dx_in[NS-2:0], gex};
		assign dvy_nxt[j] = {dy_in[NS-2:0], gey};
		assign rmx_nxt[j] = gex ? DW'(sx - {1'b0, dw_q}) : sx[DW-1:0];
		assign rmy_nxt[j] = gey ? DW'(sy - {1'b0, dh_q}) : sy[DW-1:0];
	end

	always_comb begin
		cx       = CW'(dvx_s3[NS-1]) + CW'(offx_q);
		cy       = CW'(dvy_s3[NS-1]) + CW'(offy_q);
		pix_addr = PAW'(ty_s4) * PAW'(tw_q) + PAW'(tx_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= '{default: 1'b0};
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1    <= accept;
			vld_s2    <= vld_s1;
			vld_s3[0] <= vld_s2;
			for (int j = 1; j < NS; j++) begin
				vld_s3[j] <= vld_s3[j-1];
			end
			vld_s4 <= vld_s3[NS-1];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5 && (op_s5 == OP_SAMPLE);
			vld_s7 <= vld_s6;
			done_q <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;

		cmd_s2 <= cmd_s1;
		px_s2  <= NS'(PXW'(cmd_s1.dest_col) * PXW'(tile_w_q));
		py_s2  <= NS'(PYW'(cmd_s1.dest_row) * PYW'(tile_h_q));

		cmd_s3[0] <= cmd_s2;
		for (int j = 1; j < NS; j++) begin
			cmd_s3[j] <= cmd_s3[j-1];
		end
		dvx_s3 <= dvx_nxt;
		dvy_s3 <= dvy_nxt;
		rmx_s3 <= rmx_nxt;
		rmy_s3 <= rmy_nxt;

		cmd_s4 <= cmd_s3[NS-1];
		tx_s4  <= (cx >= CW'(tw_q)) ? tw_q - TWW'(1) : TWW'(cx);
		ty_s4  <= (cy >= CW'(th_q)) ? th_q - THW'(1) : THW'(cy);

		op_s5       <= cmd_s4.op;
		ram_addr_s5 <= (cmd_s4.op == OP_LOAD) ? cmd_s4.texel_addr : pix_addr[ADDR_W-1:0];
		rgba_s5     <= cmd_s4.texel_rgba;
		col_s5      <= cmd_s4.dest_col;
		row_s5      <= cmd_s4.dest_row;

		col_s6 <= col_s5;
		row_s6 <= row_s5;

		prod_r_s7 <= (2*CHAN_W)'(texel[CHAN_W-1:0]) * (2*CHAN_W)'(cfg_tint_q[CHAN_W-1:0]);
		prod_g_s7 <= (2*CHAN_W)'(texel[2*CHAN_W-1:CHAN_W]) *
			(2*CHAN_W)'(cfg_tint_q[2*CHAN_W-1:CHAN_W]);
		prod_b_s7 <= (2*CHAN_W)'(texel[3*CHAN_W-1:2*CHAN_W]) *
			(2*CHAN_W)'(cfg_tint_q[3*CHAN_W-1:2*CHAN_W]);
		alpha_s7  <= (texel[4*CHAN_W-1:3*CHAN_W] == FULL) ?
			cfg_tint_q[4*CHAN_W-1:3*CHAN_W] : texel[4*CHAN_W-1:3*CHAN_W];
		col_s7 <= col_s6;
		row_s7 <= row_s6;

		result_q.out_red   <= div255(prod_r_s7);
		result_q.out_green <= div255(prod_g_s7);
		result_q.out_blue  <= div255(prod_b_s7);
		result_q.out_alpha <= alpha_s7;
		result_q.out_col   <= col_s7;
		result_q.out_row   <= row_s7;
	end

	// Loads and samples reach the single RAM port at the same stage and in order,
	// so a sample always sees every load accepted before it.
	sts_ram #(
		.WIDTH(RGBA_W),
		.DEPTH(STORE_DEPTH)
	) u_texel_store (
		.clk  (clk),
		.we   (vld_s5 && (op_s5 == OP_LOAD)),
		.addr (ram_addr_s5),
		.wdata(rgba_s5),
		.rdata(texel)
	);

	assign done   = done_q;
	assign result = result_q;

endmodule

/* hw/rtl/sts_checker.sv */
// Port-level checker for the scaled tinted sprite sampler, bound to the top level.
// Depends on sts_pkg and scaled_tinted_sprite_sampler_macros.svh.
`include "scaled_tinted_sprite_sampler_macros.svh"

module sts_checker
	import sts_pkg::*;
#(
	parameter int TEX_WIDTH_MAX  = 64,
	parameter int TEX_HEIGHT_MAX = 64
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t cmd,
	input logic done,
	input res_t result,
	input logic psel,
	input logic penable,
	input logic pwrite
);

	localparam int TWW = $clog2(TEX_WIDTH_MAX + 1);
	localparam int THW = $clog2(TEX_HEIGHT_MAX + 1);
	localparam int NS  = (COL_W + TWW > ROW_W + THW) ? COL_W + TWW : ROW_W + THW;
	localparam int LAT = NS + 7;

	`STS_ASSERT_NEXT(a_cfg_write_busy, clk, arst_n, psel && penable && pwrite, busy, "register write did not raise busy")
	`STS_ASSERT_DELAY(a_sample_result, clk, arst_n, start && !busy && cmd.op == OP_SAMPLE, LAT, done && result.out_col == $past(cmd.dest_col, LAT) && result.out_row == $past(cmd.dest_row, LAT), "sample item result missing or misplaced")
	`STS_ASSERT_DELAY(a_load_silent, clk, arst_n, start && !busy && cmd.op == OP_LOAD, LAT, !done, "load item produced a result")

endmodule

bind scaled_tinted_sprite_sampler sts_checker #(
	.TEX_WIDTH_MAX (TEX_WIDTH_MAX),
	.TEX_HEIGHT_MAX(TEX_HEIGHT_MAX)
) u_sts_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result),
	.psel   (psel),
	.penable(penable),
	.pwrite (pwrite)
);
